FILE: hdl/bat_pkg.sv
package bat_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int LANES            = 3;

   // CORDIC datapath widths: x/y in Q2.30 with headroom, angle accumulator wide
   // enough for a full Q3.12 angle taken to Q3.30
   localparam int CW = 34;
   localparam int ZW = 36;

   localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [CW-1:0] CORDIC_K    = 34'sd652032874;
   localparam logic signed [31:0]   ONE_Q16     = 32'sd65536;
   localparam logic signed [31:0]   SAT_MAX     = 32'sh7FFF_FFFF;
   localparam logic signed [31:0]   SAT_MIN     = 32'sh8000_0000;

   localparam logic [1:0] ROW_LAST = 2'd3;

   typedef logic signed [CW-1:0] trig_type;
   typedef logic [3:0][31:0]     row_type;
   typedef row_type [2:0]        mat_type;

   typedef struct packed {
      logic signed [31:0] fixed_x;
      logic signed [31:0] fixed_y;
      logic signed [31:0] fixed_z;
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic signed [31:0] move_z;
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] entry_0;
      logic signed [31:0] entry_1;
      logic signed [31:0] entry_2;
      logic signed [31:0] entry_3;
      logic               last_row;
   } rsp_type;

   typedef struct packed {
      logic                 neg;
      logic signed [ZW-1:0] z;
   } red_type;

   // atan(2^-i) in Q2.30, truncated
   function automatic logic [31:0] atan_q30(input int idx);
      logic [31:0] v;
      case (idx)
         0:       v = 32'h3243F6A8;
         1:       v = 32'h1DAC6705;
         2:       v = 32'h0FADBAFC;
         3:       v = 32'h07F56EA6;
         4:       v = 32'h03FEAB76;
         5:       v = 32'h01FFD55B;
         6:       v = 32'h00FFFAAA;
         7:       v = 32'h007FFF55;
         8:       v = 32'h003FFFEA;
         9:       v = 32'h001FFFFD;
         10:      v = 32'h000FFFFF;
         11:      v = 32'h0007FFFF;
         12:      v = 32'h0003FFFF;
         13:      v = 32'h0001FFFF;
         14:      v = 32'h0000FFFF;
         15:      v = 32'h00007FFF;
         16:      v = 32'h00003FFF;
         17:      v = 32'h00001FFF;
         18:      v = 32'h00000FFF;
         19:      v = 32'h000007FF;
         20:      v = 32'h000003FF;
         21:      v = 32'h000001FF;
         22:      v = 32'h000000FF;
         23:      v = 32'h0000007F;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   // fold the angle into [-pi/2, pi/2]; each fold flips the sign of sin and cos
   function automatic red_type angle_reduce(input logic signed [15:0] a);
      red_type r;
      r.z   = ZW'(signed'({a, 18'b0}));
      r.neg = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (r.z > Q30_HALF_PI) begin
            r.z   = r.z - Q30_PI;
            r.neg = ~r.neg;
         end else if (r.z < -Q30_HALF_PI) begin
            r.z   = r.z + Q30_PI;
            r.neg = ~r.neg;
         end
      end
      return r;
   endfunction

   // product with Q30 rounding (half up)
   function automatic logic signed [37:0] mulr30(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
      logic signed [67:0] p;
      p = 68'(a) * 68'(b) + (68'sd1 <<< 29);
      return p[67:30];
   endfunction

   // product with Q16 rounding (half up)
   function automatic logic signed [47:0] mulr16(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + (64'sd1 <<< 15);
      return p[63:16];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
      logic signed [31:0] r;
      if (v > 52'(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (v < 52'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/build_affine_transform_3d.sv
// Affine 3D transform matrix builder.
// req_ channel: one transaction carries the fixed point, shift vector, three
// rotation angles (Q3.12 radians) and per-axis scale (all Q16.16 otherwise).
// rsp_ channel: four transactions per request, rows 0..3 of the homogeneous
// matrix T * Tf~ * Rz * Ry * Rx * S * Tf, in order; last_row marks row 3.
// Row 0 reaches rsp_valid through 1 angle fold register loaded at the accepting
// edge, CORDIC_STEPS rotation stages, 5 matrix stages, the row buffer load and
// 1 output register; rows follow one per cycle while rsp_ready stays high.
// The four rows of each request share the single result channel, which bounds
// the sustained request rate; requests are accepted every cycle until the row
// buffer backs up, and the pipeline itself takes one transaction per cycle.
// A stall on rsp_ready holds the output register, then the row buffer, then
// freezes the whole pipeline, dropping req_ready; nothing is lost or repeated.
// Reset clears all valid bits and the row buffer's busy flag and row count;
// no request is in flight afterwards and no data state needs clearing.
module build_affine_transform_3d import bat_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     adv;
   logic     cor_valid;
   req_type  cor_req;
   trig_type cor_cos [LANES];
   trig_type cor_sin [LANES];
   logic     mat_valid;
   mat_type  mat;
   logic     buf_ready;

   // advance the whole pipeline unless a finished matrix cannot leave
   assign adv       = !mat_valid || buf_ready;
   assign req_ready = adv;

   // sine and cosine of the three angles, one CORDIC stage per iteration
   bat_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .out_valid (cor_valid),
      .out_req   (cor_req),
      .cos_out   (cor_cos),
      .sin_out   (cor_sin)
   );

   // rotation, scale and translation column
   bat_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (cor_valid),
      .in_req    (cor_req),
      .cos_in    (cor_cos),
      .sin_in    (cor_sin),
      .out_valid (mat_valid),
      .out_mat   (mat)
   );

   // hold one matrix and hand it out a row per transaction
   bat_rows u_rows (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .in_mat    (mat),
      .in_ready  (buf_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/bat_cordic.sv
module bat_cordic import bat_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  req_type  in_req,
   output logic     out_valid,
   output req_type  out_req,
   output trig_type cos_out [LANES],
   output trig_type sin_out [LANES]
);

   trig_type             x_ff   [STEPS+1][LANES];
   trig_type             y_ff   [STEPS+1][LANES];
   logic signed [ZW-1:0] z_ff   [STEPS+1][LANES];
   logic                 neg_ff [STEPS+1][LANES];
   req_type              req_ff [STEPS+1];
   logic [STEPS:0]       v_ff;
   logic signed [15:0]   ang    [LANES];
   red_type              red    [LANES];

   assign ang[0] = in_req.angle_x;
   assign ang[1] = in_req.angle_y;
   assign ang[2] = in_req.angle_z;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         red[l] = angle_reduce(ang[l]);
      end
   end

   // valid bits advance with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[STEPS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         req_ff[0] <= in_req;
         for (int l = 0; l < LANES; l++) begin
            x_ff[0][l]   <= CORDIC_K;
            y_ff[0][l]   <= '0;
            z_ff[0][l]   <= red[l].z;
            neg_ff[0][l] <= red[l].neg;
         end
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic signed [ZW-1:0] ATAN_K = ZW'(signed'({1'b0, atan_q30(k)}));
      always_ff @(posedge clock) begin
         if (en) begin
            req_ff[k+1] <= req_ff[k];
            for (int l = 0; l < LANES; l++) begin
               neg_ff[k+1][l] <= neg_ff[k][l];
               if (!z_ff[k][l][ZW-1]) begin
                  x_ff[k+1][l] <= x_ff[k][l] - (y_ff[k][l] >>> k);
                  y_ff[k+1][l] <= y_ff[k][l] + (x_ff[k][l] >>> k);
                  z_ff[k+1][l] <= z_ff[k][l] - ATAN_K;
               end else begin
                  x_ff[k+1][l] <= x_ff[k][l] + (y_ff[k][l] >>> k);
                  y_ff[k+1][l] <= y_ff[k][l] - (x_ff[k][l] >>> k);
                  z_ff[k+1][l] <= z_ff[k][l] + ATAN_K;
               end
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         cos_out[l] = neg_ff[STEPS][l] ? -x_ff[STEPS][l] : x_ff[STEPS][l];
         sin_out[l] = neg_ff[STEPS][l] ? -y_ff[STEPS][l] : y_ff[STEPS][l];
      end
   end

   assign out_valid = v_ff[STEPS];
   assign out_req   = req_ff[STEPS];

endmodule

FILE: hdl/bat_matrix.sv
module bat_matrix import bat_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  req_type  in_req,
   input  trig_type cos_in [LANES],
   input  trig_type sin_in [LANES],
   output logic     out_valid,
   output mat_type  out_mat
);

   logic [4:0] v_ff;
   req_type    req_ff [5];

   // stage 1: pair products, stage 2: rotation, stage 3: scaled entries,
   // stage 4: entry times fixed point, stage 5: translation column
   trig_type           p1_ff  [10];
   trig_type           cx_ff, sx_ff, sy_ff;
   trig_type           rot_ff [3][3];
   logic signed [31:0] e3_ff  [3][3];
   logic signed [31:0] e4_ff  [3][3];
   logic signed [47:0] q4_ff  [3][3];
   mat_type            mat_ff;

   logic signed [31:0] pnt [3];
   logic signed [31:0] mov [3];
   logic signed [31:0] scl [3];
   logic signed [51:0] acc [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         req_ff[0] <= in_req;
         for (int s = 1; s < 5; s++) begin
            req_ff[s] <= req_ff[s-1];
         end
      end
   end

   // stage 1 (lane 0 is x, 1 is y, 2 is z)
   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff[0] <= CW'(mulr30(cos_in[2], cos_in[1]));
         p1_ff[1] <= CW'(mulr30(cos_in[2], sin_in[0]));
         p1_ff[2] <= CW'(mulr30(cos_in[2], sin_in[1]));
         p1_ff[3] <= CW'(mulr30(sin_in[2], cos_in[0]));
         p1_ff[4] <= CW'(mulr30(sin_in[2], cos_in[1]));
         p1_ff[5] <= CW'(mulr30(sin_in[2], sin_in[0]));
         p1_ff[6] <= CW'(mulr30(sin_in[2], sin_in[1]));
         p1_ff[7] <= CW'(mulr30(cos_in[2], cos_in[0]));
         p1_ff[8] <= CW'(mulr30(cos_in[1], sin_in[0]));
         p1_ff[9] <= CW'(mulr30(cos_in[1], cos_in[0]));
         cx_ff    <= cos_in[0];
         sx_ff    <= sin_in[0];
         sy_ff    <= sin_in[1];
      end
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (en) begin
         rot_ff[0][0] <= p1_ff[0];
         rot_ff[0][1] <= CW'(mulr30(p1_ff[1], sy_ff)) - p1_ff[3];
         rot_ff[0][2] <= CW'(mulr30(p1_ff[2], cx_ff)) + p1_ff[5];
         rot_ff[1][0] <= p1_ff[4];
         rot_ff[1][1] <= CW'(mulr30(p1_ff[5], sy_ff)) + p1_ff[7];
         rot_ff[1][2] <= CW'(mulr30(p1_ff[6], cx_ff)) - p1_ff[1];
         rot_ff[2][0] <= -sy_ff;
         rot_ff[2][1] <= p1_ff[8];
         rot_ff[2][2] <= p1_ff[9];
      end
   end

   always_comb begin
      scl[0] = req_ff[1].scale_x;
      scl[1] = req_ff[1].scale_y;
      scl[2] = req_ff[1].scale_z;
      pnt[0] = req_ff[2].fixed_x;
      pnt[1] = req_ff[2].fixed_y;
      pnt[2] = req_ff[2].fixed_z;
   end

   // stage 3 and stage 4
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               e3_ff[i][j] <= sat32(52'(mulr30(rot_ff[i][j], CW'(scl[j]))));
               e4_ff[i][j] <= e3_ff[i][j];
               q4_ff[i][j] <= mulr16(e3_ff[i][j], pnt[j]);
            end
         end
      end
   end

   // stage 5: move + fixed - sum of rounded products
   always_comb begin
      mov[0] = req_ff[3].move_x;
      mov[1] = req_ff[3].move_y;
      mov[2] = req_ff[3].move_z;
      acc[0] = 52'(mov[0]) + 52'(req_ff[3].fixed_x);
      acc[1] = 52'(mov[1]) + 52'(req_ff[3].fixed_y);
      acc[2] = 52'(mov[2]) + 52'(req_ff[3].fixed_z);
      for (int i = 0; i < 3; i++) begin
         acc[i] = acc[i] - 52'(q4_ff[i][0]) - 52'(q4_ff[i][1]) - 52'(q4_ff[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mat_ff[i][0] <= e4_ff[i][0];
            mat_ff[i][1] <= e4_ff[i][1];
            mat_ff[i][2] <= e4_ff[i][2];
            mat_ff[i][3] <= sat32(acc[i]);
         end
      end
   end

   assign out_valid = v_ff[4];
   assign out_mat   = mat_ff;

endmodule

FILE: hdl/bat_rows.sv
module bat_rows import bat_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  mat_type in_mat,
   output logic    in_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   mat_type    mat_ff;
   logic       busy_ff, busy_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       out_free;
   logic       take;
   row_type    row;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign take     = !busy_ff || (out_free && cnt_ff == ROW_LAST);
   assign in_ready = take;

   always_comb begin
      if (cnt_ff == ROW_LAST) begin
         row = {ONE_Q16, 32'sd0, 32'sd0, 32'sd0};
      end else begin
         row = mat_ff[cnt_ff];
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (busy_ff && out_free) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.row_index = cnt_ff;
         rsp_data_in.entry_0   = row[0];
         rsp_data_in.entry_1   = row[1];
         rsp_data_in.entry_2   = row[2];
         rsp_data_in.entry_3   = row[3];
         rsp_data_in.last_row  = (cnt_ff == ROW_LAST);
         cnt_in                = cnt_ff + 2'd1;
         if (cnt_ff == ROW_LAST) begin
            busy_in = 1'b0;
         end
      end
      if (take && in_valid) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (take && in_valid) begin
         mat_ff <= in_mat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.last_row == (rsp_data_ff.row_index == ROW_LAST)))
      else $error("last_row flag disagrees with row index");

   a_rows_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && !rsp_data_ff.last_row) |=>
      (rsp_valid_ff && rsp_data_ff.row_index == $past(rsp_data_ff.row_index) + 2'd1))
      else $error("matrix rows not delivered back to back in order");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (take && in_valid && busy_ff) |-> (cnt_ff == ROW_LAST && out_free))
      else $error("new matrix loaded over rows still pending");

endmodule
